// ===== hdl/vtp_pkg.sv =====
// Types and constants shared by the vsync time predictor modules.
`timescale 1ns / 1ps

package vtp_pkg;

    // Fraction bits of the interval estimate (Q(EST_W-FRAC_BITS).FRAC_BITS)
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int TIME_W = 63;
    localparam int EST_W  = 40;
    localparam int NOM_W  = 24;
    localparam int CNT_W  = 32;
    localparam int SPAN_W = 48;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 40;

    // Derived widths of the loop arithmetic
    localparam int STEP_W     = EST_W - FRAC_BITS + 1;  // rounded interval
    localparam int THR_W      = EST_W - FRAC_BITS - 1;  // half interval, integer
    localparam int ERR_W      = THR_W + 1;              // small phase error, signed
    localparam int ADJ_W      = EST_W + 2;              // estimate plus frequency step
    localparam int FREQ_SHIFT = FRAC_BITS - 6;          // error/64 in Q format
    localparam int LATE_W     = NOM_W + 1;              // 1.5 x nominal

    // Stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 176;
    localparam int OUT_TUSER_W = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_NOMINAL = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FLOOR   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_CEILING = IDX_W'(2);

    // Reset values
    localparam logic [NOM_W-1:0]  NOM_RESET   = NOM_W'(166667);
    localparam logic [EST_W-1:0]  FLOOR_RESET = EST_W'(64'd10595007857);
    localparam logic [EST_W-1:0]  CEIL_RESET  = EST_W'(64'd11250369167);
    localparam logic [EST_W-1:0]  EST_RESET   = EST_W'(NOM_RESET) << FRAC_BITS;
    localparam logic [LATE_W-1:0] LATE_RESET  =
        LATE_W'(NOM_RESET) + LATE_W'(NOM_RESET >> 1);

    // Loop state carried from one wake to the next
    typedef struct packed {
        logic              started;
        logic [TIME_W-1:0] prev_wake;
        logic [TIME_W-1:0] prev_pred;
        logic [EST_W-1:0]  estimate;
        logic [CNT_W-1:0]  late_count;
        logic [CNT_W-1:0]  resync_count;
        logic [SPAN_W-1:0] max_spacing;
    } t_loop_state;

    // One result item
    typedef struct packed {
        logic [TIME_W-1:0] predicted_time;
        logic              did_resync;
        logic              was_late;
        logic [CNT_W-1:0]  late_total;
        logic [CNT_W-1:0]  resync_total;
        logic [SPAN_W-1:0] longest_interval;
    } t_result;

endpackage

// ===== hdl/vtp_loop_update.sv =====
// Single-pass update of the phase and frequency locked loop for one wake.
`timescale 1ns / 1ps

module vtp_loop_update import vtp_pkg::*; (
    input  t_loop_state       i_state,
    input  logic [TIME_W-1:0] i_wake,
    input  logic [TIME_W-1:0] i_measured,   // wake plus nominal interval
    input  logic [EST_W-1:0]  i_floor,
    input  logic [EST_W-1:0]  i_ceiling,
    input  logic [LATE_W-1:0] i_late_limit, // floor(1.5 x nominal)
    output t_loop_state       o_state,
    output t_result           o_result
);

    logic [TIME_W-1:0]       spacing;
    logic                    spacing_pos;
    logic [SPAN_W-1:0]       span_clip;
    logic                    late;
    logic                    span_grows;

    logic [EST_W:0]          est_round;
    logic [STEP_W-1:0]       step;
    logic [TIME_W-1:0]       pred_raw;
    logic [TIME_W-1:0]       err;
    logic [TIME_W-1:0]       err_mag;
    logic [THR_W-1:0]        threshold;
    logic                    resync;

    logic signed [ERR_W-1:0] err_n;
    logic signed [ERR_W-1:0] err_div;
    logic signed [ADJ_W-1:0] err_ext;
    logic signed [ADJ_W-1:0] est_sum;
    logic signed [ADJ_W-1:0] est_lo;
    logic signed [ADJ_W-1:0] est_clamp;
    logic signed [ADJ_W-1:0] floor_s;
    logic signed [ADJ_W-1:0] ceil_s;
    logic [TIME_W-1:0]       pred_fine;
    logic [TIME_W-1:0]       predicted;

    // Wake spacing: signed 63-bit wrapped difference
    assign spacing     = i_wake - i_state.prev_wake;
    assign spacing_pos = !spacing[TIME_W-1] && (|spacing);
    assign span_clip   = (|spacing[TIME_W-2:SPAN_W]) ? {SPAN_W{1'b1}}
                                                     : spacing[SPAN_W-1:0];
    assign late        = i_state.started && spacing_pos
                         && (spacing > TIME_W'(i_late_limit));
    assign span_grows  = i_state.started && spacing_pos
                         && (span_clip > i_state.max_spacing);

    // Phase prediction from the rounded estimate
    assign est_round = {1'b0, i_state.estimate}
                       + ((EST_W + 1)'(1) << (FRAC_BITS - 1));
    assign step      = est_round[EST_W:FRAC_BITS];
    assign pred_raw  = i_state.prev_pred + TIME_W'(step);
    assign err       = i_measured - pred_raw;
    assign err_mag   = err[TIME_W-1] ? (~err + TIME_W'(1)) : err;
    assign threshold = i_state.estimate[EST_W-1:FRAC_BITS+1];
    assign resync    = i_state.started && (err_mag > TIME_W'(threshold));

    // Small-error path: error fits ERR_W bits whenever no resync happens
    assign err_n   = signed'(err[ERR_W-1:0]);
    // error/8 truncated toward zero
    assign err_div = (err_n + (err_n[ERR_W-1] ? ERR_W'(7) : ERR_W'(0))) >>> 3;
    assign pred_fine = pred_raw + {{(TIME_W - ERR_W){err_div[ERR_W-1]}}, err_div};

    // Frequency step error/64 and clamp; floor first, ceiling wins
    assign err_ext   = {{(ADJ_W - ERR_W){err_n[ERR_W-1]}}, err_n};
    assign est_sum   = signed'({2'b00, i_state.estimate}) + (err_ext <<< FREQ_SHIFT);
    assign floor_s   = signed'({2'b00, i_floor});
    assign ceil_s    = signed'({2'b00, i_ceiling});
    assign est_lo    = (est_sum < floor_s) ? floor_s : est_sum;
    assign est_clamp = (est_lo > ceil_s) ? ceil_s : est_lo;

    assign predicted = (!i_state.started || resync) ? i_measured : pred_fine;

    // Next loop state
    always_comb begin
        o_state           = i_state;
        o_state.started   = 1'b1;
        o_state.prev_wake = i_wake;
        o_state.prev_pred = predicted;
        if (i_state.started && !resync) begin
            o_state.estimate = est_clamp[EST_W-1:0];
        end
        if (late && !(&i_state.late_count)) begin
            o_state.late_count = i_state.late_count + CNT_W'(1);
        end
        if (resync && !(&i_state.resync_count)) begin
            o_state.resync_count = i_state.resync_count + CNT_W'(1);
        end
        if (span_grows) begin
            o_state.max_spacing = span_clip;
        end
    end

    // Result item reports the statistics after this update
    always_comb begin
        o_result.predicted_time   = predicted;
        o_result.did_resync       = resync;
        o_result.was_late         = late;
        o_result.late_total       = o_state.late_count;
        o_result.resync_total     = o_state.resync_count;
        o_result.longest_interval = o_state.max_spacing;
    end

endmodule

// ===== hdl/vsync_time_predictor.sv =====
// Top level of the vsync time predictor: stream ports, registers and loop state.
`timescale 1ns / 1ps

// Takes one wake timestamp per request and returns one predicted scan-out time
// with loop status and saturating statistics. A new wake can be accepted in
// every cycle while the result side does not hold it back. An accepted request
// lands in the input register, and the combinational loop update loads the
// result register from it. Back-pressure on the result side stalls the input
// register, so the input side keeps accepting as long as the result register
// is free or being drained. The configuration port is always ready; write it
// only while no wake is in flight. Writing the nominal interval also reloads
// the interval estimate.

module vsync_time_predictor import vtp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Wake stream; tdata: [62:0] wake_time, [63] zero pad
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // Prediction stream; tdata: [62:0] predicted_time, [94:63] late_total,
    // [126:95] resync_total, [174:127] longest_interval, [175] zero pad
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // tuser: [0] did_resync, [1] was_late
    output logic [OUT_TUSER_W-1:0] o_m_tuser,
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    logic [NOM_W-1:0]  r_nominal;
    logic [EST_W-1:0]  r_floor;
    logic [EST_W-1:0]  r_ceiling;
    logic [LATE_W-1:0] r_late_limit;

    logic              r_in_valid;
    logic [TIME_W-1:0] r_wake;
    logic [TIME_W-1:0] r_measured;

    t_loop_state       r_state;
    t_loop_state       n_state;
    t_result           n_result;

    logic              r_out_valid;
    t_result           r_out;

    logic              in_take;
    logic              advance;
    logic              cfg_take;
    logic [NOM_W-1:0]  cfg_nominal;

    // Handshake control
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign in_take     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;
    assign cfg_nominal = i_cfg_data[NOM_W-1:0];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal    <= NOM_RESET;
            r_floor      <= FLOOR_RESET;
            r_ceiling    <= CEIL_RESET;
            r_late_limit <= LATE_RESET;
        end else if (cfg_take) begin
            case (i_cfg_index)
                REG_NOMINAL: begin
                    r_nominal    <= cfg_nominal;
                    r_late_limit <= LATE_W'(cfg_nominal) + LATE_W'(cfg_nominal >> 1);
                end
                REG_FLOOR:   r_floor   <= i_cfg_data[EST_W-1:0];
                REG_CEILING: r_ceiling <= i_cfg_data[EST_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Input payload: wake and measured time
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_wake     <= i_s_tdata[TIME_W-1:0];
            r_measured <= i_s_tdata[TIME_W-1:0] + TIME_W'(r_nominal);
        end
    end

    vtp_loop_update u_loop (
        .i_state      (r_state),
        .i_wake       (r_wake),
        .i_measured   (r_measured),
        .i_floor      (r_floor),
        .i_ceiling    (r_ceiling),
        .i_late_limit (r_late_limit),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // Loop state; a nominal write reloads the estimate when no wake advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.started      <= 1'b0;
            r_state.prev_wake    <= '0;
            r_state.prev_pred    <= '0;
            r_state.estimate     <= EST_RESET;
            r_state.late_count   <= '0;
            r_state.resync_count <= '0;
            r_state.max_spacing  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end else if (cfg_take && (i_cfg_index == REG_NOMINAL)) begin
            r_state.estimate <= EST_W'(cfg_nominal) << FRAC_BITS;
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.longest_interval, r_out.resync_total,
                         r_out.late_total, r_out.predicted_time};
    assign o_m_tuser  = {r_out.was_late, r_out.did_resync};

    // A result only appears after a request sat in the input register
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_in_valid))
        else $error("result valid without a pending wake");

    // Input side only stalls when the input register holds a request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // A reported resync is always counted
    a_resync_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.did_resync) |-> (r_out.resync_total != '0))
        else $error("resync flagged but resync_total is zero");

    // A reported late wake is always counted
    a_late_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.was_late) |-> (r_out.late_total != '0))
        else $error("late wake flagged but late_total is zero");

endmodule

// ===== tb/tb_vsync_time_predictor.sv =====
// Self-checking testbench for the vsync time predictor: random wake streams against a loop model.
`timescale 1ns / 1ps

module tb_vsync_time_predictor;
    import vtp_pkg::*;

    // Index that decodes to no register
    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(3);

    // Flow control knobs
    localparam int IDLE_PCT     = 15;   // chance of an idle cycle on either side
    localparam int CALM_FROM    = 180;  // no idling while the count is in [CALM_FROM, CALM_TO)
    localparam int CALM_TO      = 280;
    localparam int STALL_AT     = 300;  // results seen before the long receiver hold-off
    localparam int STALL_CYCLES = 100;
    localparam int DRAIN_CYCLES = 8;    // settle time after the last result

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] value;
    } t_reg_write;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   s_valid     = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data      = '0;
    logic                   m_ready     = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [IDX_W-1:0]       cfg_index   = '0;
    logic [CFG_W-1:0]       cfg_data    = '0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;
    logic                   o_cfg_ready;

    // Register copies
    logic [NOM_W-1:0]  cf_nominal = NOM_RESET;
    logic [EST_W-1:0]  cf_floor   = FLOOR_RESET;
    logic [EST_W-1:0]  cf_ceiling = CEIL_RESET;

    // Loop state copies
    logic              lp_started   = 1'b0;
    logic [TIME_W-1:0] lp_prev_wake = '0;
    logic [TIME_W-1:0] lp_prev_pred = '0;
    logic [EST_W-1:0]  lp_estimate  = EST_RESET;
    logic [CNT_W-1:0]  lp_lates     = '0;
    logic [CNT_W-1:0]  lp_resyncs   = '0;
    logic [SPAN_W-1:0] lp_max_span  = '0;

    // Pending wakes, pending register writes, and predictions still to arrive
    logic [TIME_W-1:0] wake_q[$];
    t_reg_write        reg_q[$];
    t_result           scanout_q[$];
    t_reg_write        next_write;

    logic [TIME_W-1:0] gen_time = '0;
    int wakes_queued    = 0;
    int wakes_taken     = 0;
    int preds_seen      = 0;
    int reg_writes_left = 0;
    int stall_left      = 0;
    bit stall_done      = 1'b0;
    int errors          = 0;

    vsync_time_predictor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Signed reading of a wrapped 63-bit difference
    function automatic longint wrap_diff(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return $signed({d[TIME_W-1], d});
    endfunction

    // Loop update for one wake; returns the expected prediction and stats
    function automatic t_result predict_scanout(logic [TIME_W-1:0] wake);
        t_result           r;
        logic [TIME_W-1:0] measured;
        logic [TIME_W-1:0] pred;
        longint            span;
        longint            late_lim;
        longint            err;
        longint            est_next;
        logic [63:0]       rounded;
        logic [63:0]       mag;
        r = '0;
        measured = wake + TIME_W'(cf_nominal);

        // spacing statistics; a backward or repeated wake counts for nothing
        if (lp_started) begin
            span = wrap_diff(wake, lp_prev_wake);
            late_lim = longint'((64'(cf_nominal) * 3) >> 1);
            if (span > 0) begin
                if (span > 64'sh0000_FFFF_FFFF_FFFF) begin
                    if (lp_max_span != '1)
                        lp_max_span = '1;
                end else if (SPAN_W'(span) > lp_max_span) begin
                    lp_max_span = SPAN_W'(span);
                end
                if (span > late_lim) begin
                    r.was_late = 1'b1;
                    if (lp_lates != '1)
                        lp_lates++;
                end
            end
        end
        lp_prev_wake = wake;

        // phase and frequency tracking
        if (!lp_started) begin
            lp_started = 1'b1;
            pred = measured;
        end else begin
            rounded = (64'(lp_estimate) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            pred = lp_prev_pred + rounded[TIME_W-1:0];
            err = wrap_diff(measured, pred);
            mag = (err < 0) ? -err : err;
            if (mag > (64'(lp_estimate) >> (FRAC_BITS + 1))) begin
                pred = measured;
                r.did_resync = 1'b1;
                if (lp_resyncs != '1)
                    lp_resyncs++;
            end else begin
                est_next = longint'({24'd0, lp_estimate})
                         + err * longint'(64'd1 << (FRAC_BITS - 6));
                pred = pred + TIME_W'(err / 8);
                // floor first, so the ceiling wins when the bounds cross
                if (est_next < longint'({24'd0, cf_floor}))
                    est_next = longint'({24'd0, cf_floor});
                if (est_next > longint'({24'd0, cf_ceiling}))
                    est_next = longint'({24'd0, cf_ceiling});
                lp_estimate = est_next[EST_W-1:0];
            end
        end
        lp_prev_pred = pred;

        r.predicted_time   = pred;
        r.late_total       = lp_lates;
        r.resync_total     = lp_resyncs;
        r.longest_interval = lp_max_span;
        return r;
    endfunction

    task automatic apply_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            REG_NOMINAL: begin
                cf_nominal = value[NOM_W-1:0];
                lp_estimate = EST_W'(value[NOM_W-1:0]) << FRAC_BITS;
            end
            REG_FLOOR:   cf_floor = value[EST_W-1:0];
            REG_CEILING: cf_ceiling = value[EST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic compare_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    task automatic check_scanout(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
        t_result want;
        if (scanout_q.size() == 0) begin
            errors++;
            $display("%0t: prediction with none expected, expected nothing, actual tdata=%h tuser=%b",
                     $time, data, user);
        end else begin
            want = scanout_q.pop_front();
            compare_field("predicted_time", 64'(want.predicted_time), 64'(data[TIME_W-1:0]));
            compare_field("late_total", 64'(want.late_total), 64'(data[TIME_W +: CNT_W]));
            compare_field("resync_total", 64'(want.resync_total),
                          64'(data[TIME_W + CNT_W +: CNT_W]));
            compare_field("longest_interval", 64'(want.longest_interval),
                          64'(data[TIME_W + 2*CNT_W +: SPAN_W]));
            compare_field("did_resync", 64'(want.did_resync), 64'(user[0]));
            compare_field("was_late", 64'(want.was_late), 64'(user[1]));
        end
    endtask

    // Wake driver: one request per accepted handshake, random idle cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready) begin
                scanout_q.push_back(predict_scanout(s_data[TIME_W-1:0]));
                wakes_taken++;
            end
            if (!s_valid || o_s_tready) begin
                if (wake_q.size() > 0 &&
                    ((wakes_taken >= CALM_FROM && wakes_taken < CALM_TO) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data <= {1'b0, wake_q.pop_front()};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Prediction monitor and receiver flow control
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                check_scanout(o_m_tdata, o_m_tuser);
                preds_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (preds_seen == STALL_AT && !stall_done) begin
                // long hold-off so the block backs up into its input
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
                m_ready <= 1'b0;
            end else if (preds_seen >= CALM_FROM && preds_seen < CALM_TO) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Register write driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                apply_register(cfg_index, cfg_data);
                reg_writes_left--;
            end
            if (!cfg_valid || o_cfg_ready) begin
                if (reg_q.size() > 0) begin
                    next_write = reg_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.idx;
                    cfg_data <= next_write.value;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    task automatic queue_wake(logic [TIME_W-1:0] wake);
        wake_q.push_back(wake);
        wakes_queued++;
        gen_time = wake;
    endtask

    task automatic program_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        t_reg_write w;
        w.idx = idx;
        w.value = value;
        reg_q.push_back(w);
        reg_writes_left++;
    endtask

    task automatic wait_regs();
        while (reg_writes_left != 0)
            @(posedge i_clk);
    endtask

    // Sender pauses until every prediction is back, then the block settles
    task automatic wait_drained();
        while (wakes_taken != wakes_queued || scanout_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly steady refresh with jitter and drift; some late, backward and wild wakes
    task automatic queue_random_wakes(int count, longint drift);
        logic [63:0] nom;
        logic [63:0] jit;
        logic [63:0] gap;
        logic [63:0] wild;
        int          pick;
        nom = 64'(cf_nominal);
        jit = (nom >> 4) + 1;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            gap = nom;
            if (pick < 70) begin
                gap = nom + 64'(drift) + 64'($urandom_range(32'(2 * jit))) - jit;
            end else if (pick < 80) begin
                gap = nom * $urandom_range(4, 2) + 64'($urandom_range(32'(nom)));
            end else if (pick < 88) begin
                gap = 64'd0 - 64'($urandom_range(32'(nom)));
            end
            if (pick >= 95) begin
                wild = {$urandom, $urandom};
                queue_wake(wild[TIME_W-1:0]);
            end else begin
                queue_wake(gen_time + gap[TIME_W-1:0]);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: first wake, exact, small error, repeat, late, backward,
        // huge spacing, wraparound, and the 1.5x boundary from both sides
        queue_wake(TIME_W'(0));
        queue_wake(TIME_W'(166667));
        queue_wake(TIME_W'(334334));
        queue_wake(TIME_W'(334334));
        queue_wake(TIME_W'(833335));
        queue_wake(TIME_W'(833235));
        queue_wake(TIME_W'(64'd1 << 50) + TIME_W'(833235));
        queue_wake('1);
        queue_wake(TIME_W'(0));
        queue_wake(TIME_W'(166667));
        queue_wake(TIME_W'(416667));
        queue_wake(TIME_W'(666668));
        queue_wake(TIME_W'(833400));
        wait_drained();

        // Smallest nominal, bounds wide open
        program_reg(REG_NOMINAL, CFG_W'(1));
        program_reg(REG_FLOOR, '0);
        program_reg(REG_CEILING, '1);
        wait_regs();
        queue_random_wakes(80, 0);
        wait_drained();

        // Largest nominal, crossed bounds
        program_reg(REG_NOMINAL, CFG_W'(24'hFF_FFFF));
        program_reg(REG_FLOOR, '1);
        program_reg(REG_CEILING, '0);
        wait_regs();
        queue_random_wakes(60, 0);
        wait_drained();

        // Typical 60 Hz setup; dead index and high data bits must be ignored
        program_reg(REG_UNUSED, {$urandom, $urandom});
        program_reg(REG_NOMINAL, 40'hA5_0002_8B0B);
        program_reg(REG_FLOOR, FLOOR_RESET);
        program_reg(REG_CEILING, CEIL_RESET);
        wait_regs();
        queue_random_wakes(120, 0);
        queue_random_wakes(130, 166667 / 20);
        queue_random_wakes(130, -166667 / 20);
        wait_drained();

        // Zero nominal through the truncated data field
        program_reg(REG_NOMINAL, 40'hFF_0000_0000);
        wait_regs();
        queue_random_wakes(10, 0);
        wait_drained();

        if (errors == 0) begin
            $display("PASS vsync_time_predictor");
        end else begin
            $display("FAIL vsync_time_predictor");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAIL vsync_time_predictor");
        $finish;
    end

endmodule
